@@ rtl/smfp_pkg.sv @@
// Shared types and constants for the stack map frame parser.
// Used by smfp_parse and stack_map_frame_parser; depends on nothing else.
package smfp_pkg;

  // Parse phases, one-hot.
  typedef enum logic [12:0] {
    PH_CNT_HI  = 13'b0000000000001,
    PH_CNT_LO  = 13'b0000000000010,
    PH_FTYPE   = 13'b0000000000100,
    PH_OFF_HI  = 13'b0000000001000,
    PH_OFF_LO  = 13'b0000000010000,
    PH_LCNT_HI = 13'b0000000100000,
    PH_LCNT_LO = 13'b0000001000000,
    PH_SCNT_HI = 13'b0000010000000,
    PH_SCNT_LO = 13'b0000100000000,
    PH_TAG     = 13'b0001000000000,
    PH_DATA_HI = 13'b0010000000000,
    PH_DATA_LO = 13'b0100000000000,
    PH_DONE    = 13'b1000000000000
  } phase_e;

  // Record kinds.
  localparam logic [2:0] RK_HEADER = 3'd0;
  localparam logic [2:0] RK_LCOUNT = 3'd1;
  localparam logic [2:0] RK_SCOUNT = 3'd2;
  localparam logic [2:0] RK_ITEM   = 3'd3;
  localparam logic [2:0] RK_ERROR  = 3'd4;
  localparam logic [2:0] RK_EMPTY  = 3'd5;

  // Frame kinds.
  localparam logic [2:0] FK_SAME     = 3'd0;
  localparam logic [2:0] FK_ONE      = 3'd1;
  localparam logic [2:0] FK_ONE_EXT  = 3'd2;
  localparam logic [2:0] FK_CHOP     = 3'd3;
  localparam logic [2:0] FK_SAME_EXT = 3'd4;
  localparam logic [2:0] FK_APPEND   = 3'd5;
  localparam logic [2:0] FK_FULL     = 3'd6;

  // Frame type byte boundaries.
  localparam logic [7:0] FT_SAME_MAX    = 8'd63;
  localparam logic [7:0] FT_ONE_BASE    = 8'd64;
  localparam logic [7:0] FT_ONE_MAX     = 8'd127;
  localparam logic [7:0] FT_ONE_EXT     = 8'd247;
  localparam logic [7:0] FT_CHOP_MIN    = 8'd248;
  localparam logic [7:0] FT_CHOP_MAX    = 8'd250;
  localparam logic [7:0] FT_SAME_EXT    = 8'd251;
  localparam logic [7:0] FT_APPEND_MIN  = 8'd252;
  localparam logic [7:0] FT_APPEND_MAX  = 8'd254;
  localparam logic [7:0] FT_FULL        = 8'd255;

  // Verification tags that carry two data bytes.
  localparam logic [7:0] TAG_OBJECT     = 8'd7;
  localparam logic [7:0] TAG_UNINIT     = 8'd8;

  typedef struct packed {
    logic [2:0]  rec_kind;
    logic [2:0]  frame_kind;
    logic [7:0]  raw_frame_type;
    logic [15:0] offset_delta;
    logic [15:0] list_count;
    logic [7:0]  type_tag;
    logic [15:0] type_data;
    logic        in_stack;
    logic [15:0] entry_index;
    logic        last_in_table;
  } rec_t;

endpackage

@@ rtl/smfp_parse.sv @@
// Parse state and per-byte decode for the stack map frame parser.
// Depends on smfp_pkg for the phase type, codes and the record struct.
module smfp_parse (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          fire_i,
  input  logic [7:0]    byte_i,
  input  logic          start_i,
  output logic          emit_o,
  output smfp_pkg::rec_t rec_o
);
  import smfp_pkg::*;

  phase_e      phase_q, phase_d;
  logic [15:0] ent_left_q, ent_left_d;
  logic [15:0] ent_cnt_q, ent_cnt_d;
  logic [2:0]  kind_q, kind_d;
  logic [7:0]  tbyte_q, tbyte_d;
  logic [7:0]  hi_q, hi_d;
  logic [15:0] off_q, off_d;
  logic [15:0] loc_q, loc_d;
  logic [15:0] stk_q, stk_d;
  logic [7:0]  tag_q, tag_d;
  logic        halt_q, halt_d;

  logic [15:0] word;
  logic [15:0] fin_left;
  logic        fin_last;
  logic [15:0] loc_m1, stk_m1;
  logic        do_item;
  logic [15:0] item_data;
  logic        do_finish;
  logic [2:0]  rk;
  logic [15:0] lc;
  logic        instk;
  logic        last;

  assign word     = {hi_q, byte_i};
  assign fin_left = ent_left_q - 16'd1;
  assign fin_last = (fin_left == 16'd0);
  assign loc_m1   = loc_q - 16'd1;
  assign stk_m1   = stk_q - 16'd1;

  always_comb begin
    phase_d   = phase_q;
    ent_left_d = ent_left_q;
    ent_cnt_d = ent_cnt_q;
    kind_d    = kind_q;
    tbyte_d   = tbyte_q;
    hi_d      = hi_q;
    off_d     = off_q;
    loc_d     = loc_q;
    stk_d     = stk_q;
    tag_d     = tag_q;
    halt_d    = halt_q;
    emit_o    = 1'b0;
    do_item   = 1'b0;
    item_data = 16'd0;
    do_finish = 1'b0;
    rk        = RK_HEADER;
    lc        = 16'd0;
    instk     = 1'b0;
    last      = 1'b0;

    if (start_i) begin
      phase_d    = PH_CNT_LO;
      ent_left_d = 16'd0;
      ent_cnt_d  = 16'd0;
      kind_d     = FK_SAME;
      tbyte_d    = 8'd0;
      hi_d       = byte_i;
      off_d      = 16'd0;
      loc_d      = 16'd0;
      stk_d      = 16'd0;
      tag_d      = 8'd0;
      halt_d     = 1'b0;
    end else if (!halt_q) begin
      case (phase_q)
        PH_CNT_HI: begin
          hi_d    = byte_i;
          phase_d = PH_CNT_LO;
        end
        PH_CNT_LO: begin
          ent_left_d = word;
          if (word == 16'd0) begin
            emit_o  = 1'b1;
            rk      = RK_EMPTY;
            last    = 1'b1;
            phase_d = PH_DONE;
          end else begin
            phase_d = PH_FTYPE;
          end
        end
        PH_FTYPE: begin
          tbyte_d = byte_i;
          loc_d   = 16'd0;
          stk_d   = 16'd0;
          phase_d = PH_OFF_HI;
          if (byte_i <= FT_SAME_MAX) begin
            kind_d    = FK_SAME;
            off_d     = {8'd0, byte_i};
            emit_o    = 1'b1;
            do_finish = 1'b1;
          end else if (byte_i <= FT_ONE_MAX) begin
            kind_d  = FK_ONE;
            off_d   = {8'd0, byte_i - FT_ONE_BASE};
            stk_d   = 16'd1;
            emit_o  = 1'b1;
            phase_d = PH_TAG;
          end else if (byte_i == FT_ONE_EXT) begin
            kind_d = FK_ONE_EXT;
          end else if (byte_i inside {[FT_CHOP_MIN:FT_CHOP_MAX]}) begin
            kind_d = FK_CHOP;
          end else if (byte_i == FT_SAME_EXT) begin
            kind_d = FK_SAME_EXT;
          end else if (byte_i inside {[FT_APPEND_MIN:FT_APPEND_MAX]}) begin
            kind_d = FK_APPEND;
          end else if (byte_i == FT_FULL) begin
            kind_d = FK_FULL;
          end else begin
            // Reserved frame type: report it and halt until the next start.
            kind_d  = FK_SAME;
            off_d   = 16'd0;
            emit_o  = 1'b1;
            rk      = RK_ERROR;
            last    = 1'b1;
            halt_d  = 1'b1;
            phase_d = PH_DONE;
          end
        end
        PH_OFF_HI: begin
          hi_d    = byte_i;
          phase_d = PH_OFF_LO;
        end
        PH_LCNT_HI: begin
          hi_d    = byte_i;
          phase_d = PH_LCNT_LO;
        end
        PH_SCNT_HI: begin
          hi_d    = byte_i;
          phase_d = PH_SCNT_LO;
        end
        PH_DATA_HI: begin
          hi_d    = byte_i;
          phase_d = PH_DATA_LO;
        end
        PH_OFF_LO: begin
          off_d  = word;
          emit_o = 1'b1;
          if (kind_q == FK_ONE_EXT) begin
            stk_d   = 16'd1;
            phase_d = PH_TAG;
          end else if (kind_q == FK_APPEND) begin
            loc_d   = {8'd0, tbyte_q - FT_SAME_EXT};
            phase_d = PH_TAG;
          end else if (kind_q == FK_FULL) begin
            phase_d = PH_LCNT_HI;
          end else begin
            do_finish = 1'b1;
          end
        end
        PH_LCNT_LO: begin
          loc_d   = word;
          emit_o  = 1'b1;
          rk      = RK_LCOUNT;
          lc      = word;
          phase_d = (word != 16'd0) ? PH_TAG : PH_SCNT_HI;
        end
        PH_SCNT_LO: begin
          stk_d  = word;
          emit_o = 1'b1;
          rk     = RK_SCOUNT;
          lc     = word;
          if (word != 16'd0) begin
            phase_d = PH_TAG;
          end else begin
            do_finish = 1'b1;
          end
        end
        PH_TAG: begin
          tag_d = byte_i;
          if (byte_i inside {TAG_OBJECT, TAG_UNINIT}) begin
            phase_d = PH_DATA_HI;
          end else begin
            do_item = 1'b1;
          end
        end
        PH_DATA_LO: begin
          do_item   = 1'b1;
          item_data = word;
        end
        default: begin
        end
      endcase

      // A verification type item: locals list first, then the stack list.
      if (do_item) begin
        emit_o = 1'b1;
        rk     = RK_ITEM;
        if (loc_q != 16'd0) begin
          loc_d = loc_m1;
          if (loc_m1 != 16'd0) begin
            phase_d = PH_TAG;
          end else if (kind_q == FK_FULL) begin
            phase_d = PH_SCNT_HI;
          end else begin
            do_finish = 1'b1;
          end
        end else begin
          instk = 1'b1;
          stk_d = stk_m1;
          if (stk_m1 != 16'd0) begin
            phase_d = PH_TAG;
          end else begin
            do_finish = 1'b1;
          end
        end
      end

      if (do_finish) begin
        ent_left_d = fin_left;
        ent_cnt_d  = ent_cnt_q + 16'd1;
        last       = fin_last;
        phase_d    = fin_last ? PH_DONE : PH_FTYPE;
      end
    end
  end

  // The record shows the frame fields as updated by this byte, and the
  // entry index from before a frame is closed.
  always_comb begin
    rec_o.rec_kind       = rk;
    rec_o.frame_kind     = kind_d;
    rec_o.raw_frame_type = tbyte_d;
    rec_o.offset_delta   = off_d;
    rec_o.list_count     = lc;
    rec_o.type_tag       = (rk == RK_ITEM) ? tag_d : 8'd0;
    rec_o.type_data      = item_data;
    rec_o.in_stack       = instk;
    rec_o.entry_index    = ent_cnt_q;
    rec_o.last_in_table  = last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_CNT_HI;
      ent_left_q <= 16'd0;
      ent_cnt_q  <= 16'd0;
      kind_q     <= FK_SAME;
      tbyte_q    <= 8'd0;
      hi_q       <= 8'd0;
      off_q      <= 16'd0;
      loc_q      <= 16'd0;
      stk_q      <= 16'd0;
      tag_q      <= 8'd0;
      halt_q     <= 1'b0;
    end else if (fire_i) begin
      phase_q    <= phase_d;
      ent_left_q <= ent_left_d;
      ent_cnt_q  <= ent_cnt_d;
      kind_q     <= kind_d;
      tbyte_q    <= tbyte_d;
      hi_q       <= hi_d;
      off_q      <= off_d;
      loc_q      <= loc_d;
      stk_q      <= stk_d;
      tag_q      <= tag_d;
      halt_q     <= halt_d;
    end
  end

endmodule

@@ rtl/stack_map_frame_parser.sv @@
// Top level of the stack map frame parser: input register, parse stage and
// result register. Depends on smfp_pkg and smfp_parse.
//
// Usage: bytes of a StackMapTable attribute body enter on byte_in_i with
// in_valid_i; start_req_i marks the high byte of the 16-bit entry count.
// A transfer happens at a clock edge where valid is high and stall is low.
// Each accepted byte gives zero or one record on the output channel
// (frame header, full-frame list count, type item, error or empty table).
// A byte passes from the input register through the parse stage into the
// result register, which holds its record while out_valid_o is high. Throughput is
// one byte per cycle while the receiver does not stall: the parse state
// advances once per byte in the stage between the input and result registers.
// When the receiver stalls, the record holds in the result register; a byte
// already in the input register then waits too, whether it gives a record or
// not, and in_stall_o stays high while it waits. Reset empties both registers
// and puts the parser in the state that takes the next byte as the count
// high byte.
module stack_map_frame_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  byte_in_i,
  input  logic        start_req_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  rec_kind_o,
  output logic [2:0]  frame_kind_o,
  output logic [7:0]  raw_frame_type_o,
  output logic [15:0] offset_delta_o,
  output logic [15:0] list_count_o,
  output logic [7:0]  type_tag_o,
  output logic [15:0] type_data_o,
  output logic        in_stack_o,
  output logic [15:0] entry_index_o,
  output logic        last_in_table_o
);
  import smfp_pkg::*;

  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_start_q;
  logic       out_vld_q;
  rec_t       out_rec_q;
  logic       stage_free;
  logic       fire;
  logic       emit;
  rec_t       rec;

  assign stage_free = !out_vld_q || !out_stall_i;
  assign fire       = in_vld_q && stage_free;
  assign in_stall_o = in_vld_q && !stage_free;

  smfp_parse u_parse (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (fire),
    .byte_i  (in_byte_q),
    .start_i (in_start_q),
    .emit_o  (emit),
    .rec_o   (rec)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_vld_q <= in_valid_i;
      end
      if (stage_free) begin
        out_vld_q <= fire && emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_byte_q  <= byte_in_i;
      in_start_q <= start_req_i;
    end
    if (fire && emit) begin
      out_rec_q <= rec;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign rec_kind_o       = out_rec_q.rec_kind;
  assign frame_kind_o     = out_rec_q.frame_kind;
  assign raw_frame_type_o = out_rec_q.raw_frame_type;
  assign offset_delta_o   = out_rec_q.offset_delta;
  assign list_count_o     = out_rec_q.list_count;
  assign type_tag_o       = out_rec_q.type_tag;
  assign type_data_o      = out_rec_q.type_data;
  assign in_stack_o       = out_rec_q.in_stack;
  assign entry_index_o    = out_rec_q.entry_index;
  assign last_in_table_o  = out_rec_q.last_in_table;

endmodule
